[src/tmpg_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text mode pixel generator package
// Shared payload types, command format, operation codes and screen constants.
// ----------------------------------------------------------------------------
package tmpg_pkg;

  // Operation codes carried in the func field.
  localparam logic [1:0] FUNC_WRITE  = 2'd0;
  localparam logic [1:0] FUNC_READ   = 2'd1;
  localparam logic [1:0] FUNC_LOAD   = 2'd2;
  localparam logic [1:0] FUNC_RENDER = 2'd3;

  // Configuration register indexes.
  localparam logic REG_COLUMN_MODE = 1'b0;

  // Screen geometry and font limits.
  localparam int SCREEN_W         = 400;
  localparam int SCREEN_H         = 300;
  localparam int NARROW_ROW_LIMIT = 299;
  localparam int WIDE_ROW_LIMIT   = 296;
  localparam int NARROW_COLS      = 80;
  localparam int WIDE_COLS        = 50;
  localparam int NARROW_CELL_H    = 13;
  localparam int NARROW_CELL_W    = 5;

  // Reciprocals for the constant divisions (quotient = (v * RECIP) >> 10).
  localparam int RECIP_5  = 205;
  localparam int RECIP_13 = 79;
  localparam int RECIP_SH = 10;

  localparam logic [7:0] INK         = 8'h00;
  localparam logic [7:0] PAPER       = 8'hFF;
  localparam logic [7:0] SPACE_CHAR  = 8'h20;
  localparam logic [7:0] NARROW_FIRST = 8'd32;
  localparam logic [7:0] NARROW_LAST  = 8'd127;
  localparam logic [7:0] WIDE_END     = 8'd160;

  localparam int MAP_IDX_W = 11;
  localparam int GLYPH_AW  = 12;
  localparam int GLYPH_BYTES = 1 << GLYPH_AW;

  // Command queue geometry.
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [1:0]  func;
    logic [10:0] map_addr;
    logic [7:0]  wdata;
    logic [11:0] font_addr;
    logic [8:0]  pixel_x;
    logic [8:0]  pixel_y;
  } in_item_t;

  typedef struct packed {
    logic [7:0] pixel_value;
    logic [7:0] read_data;
    logic       is_pixel;
    logic       refresh_pending;
    logic       frame_done;
  } out_item_t;

  // Classified command handed from the front end to the back end.
  typedef struct packed {
    logic [1:0]           kind;
    logic                 mode;
    logic                 addr_ok;
    logic [MAP_IDX_W-1:0] map_idx;
    logic [7:0]           wdata;
    logic [GLYPH_AW-1:0]  font_addr;
    logic                 paper;
    logic [3:0]           glyph_row;
    logic [2:0]           bit_sel;
    logic                 last;
  } cmd_t;

  typedef struct packed {
    logic              valid;
    logic [QCNT_W-1:0] count;
  } q_stat_t;

  typedef struct packed {
    logic a_valid;
    logic b_valid;
  } front_stat_t;

endpackage

[src/text_mode_pixel_generator_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text mode pixel generator
// Character map and glyph store with a per-pixel renderer for a 400x300 screen.
//
//   Channel   Handshake                     Payload
//   input     start, busy                   item   (in_item_t)
//   result    result_valid (one-cycle)      result (out_item_t)
//   config    psel, penable, pwrite, pready paddr, pwdata, prdata
//
// One item is taken per cycle while busy is low; the result of a read or render
// passes through the second front stage, the queue, the map read, the glyph
// read and the result register. Writes and glyph loads give no result.
// After reset busy stays high while the character map is filled with spaces,
// one entry per cycle.
// busy also rises when the command queue plus front stages are full.
// Results cannot be held off; each is valid for exactly one cycle.
// ----------------------------------------------------------------------------
module text_mode_pixel_generator_top #(
  parameter int MAP_BYTES = 2048
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  tmpg_pkg::in_item_t  item,
  output logic                result_valid,
  output tmpg_pkg::out_item_t result,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import tmpg_pkg::*;

  logic        column_mode;
  logic        cfg_set;
  logic        accept;
  logic        clearing;
  logic        push;
  logic        pop;
  cmd_t        push_cmd;
  cmd_t        head;
  q_stat_t     q_stat;
  front_stat_t f_stat;
  logic [QCNT_W:0] occupancy;

  // Configuration port.
  assign pready  = 1'b1;
  assign cfg_set = psel && penable && pwrite && (paddr[2] == REG_COLUMN_MODE);
  assign prdata  = (paddr[2] == REG_COLUMN_MODE) ? {31'b0, column_mode} : 32'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      column_mode <= 1'b0;
    end else if (cfg_set) begin
      column_mode <= pwdata[0];
    end
  end

  // Input acceptance: hold off while clearing or when the queue could overflow.
  assign occupancy = (QCNT_W + 1)'(q_stat.count) + (QCNT_W + 1)'(f_stat.a_valid)
                   + (QCNT_W + 1)'(f_stat.b_valid);
  assign busy      = clearing || (occupancy >= (QCNT_W + 1)'(QDEPTH));
  assign accept    = start && !busy;

  tmpg_front #(
    .MAP_BYTES (MAP_BYTES)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .item        (item),
    .column_mode (column_mode),
    .stat        (f_stat),
    .push        (push),
    .cmd         (push_cmd)
  );

  tmpg_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .stat     (q_stat),
    .head     (head)
  );

  tmpg_back #(
    .MAP_BYTES (MAP_BYTES)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg_set      (cfg_set),
    .q_stat       (q_stat),
    .head         (head),
    .pop          (pop),
    .clearing     (clearing),
    .result_valid (result_valid),
    .result       (result)
  );

  // A read result carries no pixel and never marks the end of a frame.
  assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result.is_pixel) |-> (result.pixel_value == 8'h00) &&
                                           !result.frame_done)
    else $error("read result carries pixel data");

  // The final pixel of a frame leaves the refresh flag cleared.
  assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.frame_done) |-> !result.refresh_pending)
    else $error("refresh still pending on frame end");

  // The queue never holds more than its depth.
  assert property (@(posedge clk) disable iff (rst)
    q_stat.count <= QCNT_W'(QDEPTH))
    else $error("command queue overflow");

  // Nothing is in flight while the map is being cleared.
  assert property (@(posedge clk) disable iff (rst)
    clearing |-> (q_stat.count == '0) && !f_stat.a_valid && !f_stat.b_valid &&
                 !result_valid)
    else $error("item in flight during map clear");

endmodule

[src/tmpg_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text mode pixel generator front end
// Accepts items, divides pixel coordinates into cells and classifies them.
// ----------------------------------------------------------------------------
module tmpg_front #(
  parameter int MAP_BYTES = 2048
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  accept,
  input  tmpg_pkg::in_item_t    item,
  input  logic                  column_mode,
  output tmpg_pkg::front_stat_t stat,
  output logic                  push,
  output tmpg_pkg::cmd_t        cmd
);
  import tmpg_pkg::*;

  logic       a_valid;
  in_item_t   a_item;
  logic       a_mode;
  logic       b_valid;
  in_item_t   b_item;
  logic       b_mode;
  logic [6:0] b_q5;
  logic [5:0] b_q13;

  logic [16:0] prod5;
  logic [15:0] prod13;
  logic [8:0]  rem5_full;
  logic [8:0]  rem13_full;
  logic [10:0] idx_narrow;
  logic [10:0] idx_wide;
  logic        paper;
  logic        last;
  logic        addr_ok;

  // Stage valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
    end else begin
      a_valid <= accept;
      b_valid <= a_valid;
    end
  end

  // Reciprocal multiplications for x / 5 and y / 13.
  assign prod5  = 17'(a_item.pixel_x) * 17'(RECIP_5);
  assign prod13 = 16'(a_item.pixel_y) * 16'(RECIP_13);

  // Stage payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      a_item <= item;
      a_mode <= column_mode;
    end
    b_item <= a_item;
    b_mode <= a_mode;
    b_q5   <= prod5[16:RECIP_SH];
    b_q13  <= prod13[15:RECIP_SH];
  end

  // Remainders, cell index and screen limits.
  always_comb begin
    rem5_full  = b_item.pixel_x - 9'(b_q5) * 9'(NARROW_CELL_W);
    rem13_full = b_item.pixel_y - 9'(b_q13) * 9'(NARROW_CELL_H);
    idx_narrow = 11'(b_q13) * 11'(NARROW_COLS) + 11'(b_q5);
    idx_wide   = 11'(b_item.pixel_y[8:3]) * 11'(WIDE_COLS) + 11'(b_item.pixel_x[8:3]);
    paper      = (b_item.pixel_x >= 9'(SCREEN_W)) ||
                 (b_mode ? (b_item.pixel_y >= 9'(WIDE_ROW_LIMIT))
                         : (b_item.pixel_y >= 9'(NARROW_ROW_LIMIT)));
    last       = (b_item.pixel_x == 9'(SCREEN_W - 1)) &&
                 (b_item.pixel_y == 9'(SCREEN_H - 1));
    addr_ok    = {2'b00, b_item.map_addr} < 13'(MAP_BYTES);
  end

  // Build the command for the queue.
  always_comb begin
    cmd           = '0;
    cmd.kind      = b_item.func;
    cmd.mode      = b_mode;
    cmd.wdata     = b_item.wdata;
    cmd.font_addr = b_item.font_addr;
    unique case (b_item.func) inside
      FUNC_WRITE, FUNC_READ: begin
        cmd.addr_ok = addr_ok;
        cmd.map_idx = b_item.map_addr;
      end
      FUNC_LOAD: begin
        cmd.addr_ok = 1'b0;
      end
      FUNC_RENDER: begin
        cmd.addr_ok   = 1'b1;
        cmd.paper     = paper;
        cmd.last      = last;
        // An off-screen pixel reads cell zero so the map address stays in range.
        cmd.map_idx   = paper ? '0 : (b_mode ? idx_wide : idx_narrow);
        cmd.glyph_row = b_mode ? {1'b0, b_item.pixel_y[2:0]} : rem13_full[3:0];
        cmd.bit_sel   = b_mode ? b_item.pixel_x[2:0] : 3'd7 - rem5_full[2:0];
      end
      default: begin
        cmd.addr_ok = 1'b0;
      end
    endcase
  end

  assign push         = b_valid;
  assign stat.a_valid = a_valid;
  assign stat.b_valid = b_valid;

endmodule

[src/tmpg_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text mode pixel generator command queue
// Small first-in first-out buffer that decouples front end and back end.
// ----------------------------------------------------------------------------
module tmpg_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  tmpg_pkg::cmd_t    push_cmd,
  input  logic              pop,
  output tmpg_pkg::q_stat_t stat,
  output tmpg_pkg::cmd_t    head
);
  import tmpg_pkg::*;

  cmd_t              slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  // Pointer and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  assign head       = slots[rd_ptr];
  assign stat.valid = (count != '0);
  assign stat.count = count;

endmodule

[src/tmpg_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text mode pixel generator back end
// Owns the character map and glyph store, and produces read and pixel results.
// ----------------------------------------------------------------------------
module tmpg_back #(
  parameter int MAP_BYTES = 2048
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_set,
  input  tmpg_pkg::q_stat_t    q_stat,
  input  tmpg_pkg::cmd_t       head,
  output logic                 pop,
  output logic                 clearing,
  output logic                 result_valid,
  output tmpg_pkg::out_item_t  result
);
  import tmpg_pkg::*;

  localparam int AW = $clog2(MAP_BYTES);

  logic [7:0] char_map [MAP_BYTES];
  logic [7:0] glyph_store [GLYPH_BYTES];

  logic [AW-1:0] clr_addr;
  logic          flag;
  logic          flag_after;
  logic          map_we;
  logic          glyph_we;
  logic [AW-1:0] map_addr;

  // First back stage: map byte available.
  logic       b1_valid;
  logic       b1_is_pixel;
  logic       b1_mode;
  logic       b1_addr_ok;
  logic       b1_paper;
  logic [3:0] b1_row;
  logic [2:0] b1_bit_sel;
  logic       b1_last;
  logic       b1_flag;
  logic [7:0] map_q;

  // Second back stage: glyph row available.
  logic       b2_valid;
  logic       b2_is_pixel;
  logic       b2_draw;
  logic [2:0] b2_bit_sel;
  logic       b2_last;
  logic       b2_flag;
  logic [7:0] b2_rdata;
  logic [7:0] glyph_q;

  logic                code_ok;
  logic                draw;
  logic [GLYPH_AW-1:0] glyph_addr;

  assign pop      = q_stat.valid && !clearing;
  assign map_addr = AW'(head.map_idx);
  assign map_we   = pop && (head.kind == FUNC_WRITE) && head.addr_ok;
  assign glyph_we = pop && (head.kind == FUNC_LOAD);

  // Clearing pass over the character map after reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == AW'(MAP_BYTES - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  // Refresh flag as it stands after the popped command.
  always_comb begin
    flag_after = flag;
    if (map_we) begin
      flag_after = 1'b1;
    end else if ((head.kind == FUNC_RENDER) && head.last) begin
      flag_after = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      flag <= 1'b1;
    end else if (cfg_set) begin
      flag <= 1'b1;
    end else if (pop) begin
      flag <= flag_after;
    end
  end

  // Character map: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (clearing) begin
      char_map[clr_addr] <= SPACE_CHAR;
    end else if (map_we) begin
      char_map[map_addr] <= head.wdata;
    end
    if (pop) begin
      map_q <= char_map[map_addr];
    end
  end

  // Stage one control.
  always_ff @(posedge clk) begin
    if (rst) begin
      b1_valid <= 1'b0;
    end else begin
      b1_valid <= pop && ((head.kind == FUNC_READ) || (head.kind == FUNC_RENDER));
    end
  end

  always_ff @(posedge clk) begin
    b1_is_pixel <= (head.kind == FUNC_RENDER);
    b1_mode     <= head.mode;
    b1_addr_ok  <= head.addr_ok;
    b1_paper    <= head.paper;
    b1_row      <= head.glyph_row;
    b1_bit_sel  <= head.bit_sel;
    b1_last     <= head.last;
    b1_flag     <= flag_after;
  end

  // Code range check and glyph row address.
  always_comb begin
    if (b1_mode) begin
      code_ok    = (map_q < WIDE_END);
      glyph_addr = {1'b1, map_q, b1_row[2:0]};
    end else begin
      code_ok    = (map_q >= NARROW_FIRST) && (map_q <= NARROW_LAST);
      glyph_addr = {map_q, b1_row};
    end
    draw = b1_is_pixel && !b1_paper && code_ok;
  end

  // Glyph store: written by loads, read one stage after the map.
  always_ff @(posedge clk) begin
    if (glyph_we) begin
      glyph_store[head.font_addr] <= head.wdata;
    end
    if (b1_valid) begin
      glyph_q <= glyph_store[glyph_addr];
    end
  end

  // Stage two registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      b2_valid <= 1'b0;
    end else begin
      b2_valid <= b1_valid;
    end
  end

  always_ff @(posedge clk) begin
    b2_is_pixel <= b1_is_pixel;
    b2_draw     <= draw;
    b2_bit_sel  <= b1_bit_sel;
    b2_last     <= b1_last;
    b2_flag     <= b1_flag;
    b2_rdata    <= (!b1_is_pixel && b1_addr_ok) ? map_q : 8'h00;
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= b2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!b2_is_pixel) begin
      result.pixel_value <= 8'h00;
    end else if (b2_draw && glyph_q[b2_bit_sel]) begin
      result.pixel_value <= INK;
    end else begin
      result.pixel_value <= PAPER;
    end
    result.read_data       <= b2_rdata;
    result.is_pixel        <= b2_is_pixel;
    result.refresh_pending <= b2_flag;
    result.frame_done      <= b2_is_pixel && b2_last;
  end

endmodule
